[src/cdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Word width, default depth, operation and status codes, and the control
// and status bundles that pass between the deque chain and its controller.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 8;

    // front/back value reported for an empty deque
    localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

    // operation code of an input transaction
    typedef enum logic [1:0] {
        K_PUSH_FRONT = 2'd0,
        K_PUSH_BACK  = 2'd1,
        K_POP_FRONT  = 2'd2,
        K_POP_BACK   = 2'd3
    } t_kind;

    // result status
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        C_HOLD      = 3'd0,
        C_SHIFT_IN  = 3'd1,   // every cell takes its front-side neighbor
        C_SHIFT_OUT = 3'd2,   // every cell takes its back-side neighbor
        C_APPEND    = 3'd3,   // first empty cell takes the value
        C_DROP_TAIL = 3'd4    // last occupied cell goes empty
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // occupancy and end words of the chain
    typedef struct packed {
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic                     empty;
        logic                     full;
    } t_chain_stat;

endpackage

[src/cdq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque chain
// Holds one word and its occupied bit. Depending on the broadcast command
// it takes the word of a neighbor, appends the pushed word, or empties.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cdq_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [cdq_pkg::DATA_W-1:0]  i_left_data,
    input  logic                               i_left_valid,
    input  logic signed [cdq_pkg::DATA_W-1:0]  i_right_data,
    input  logic                               i_right_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]  o_data,
    output logic                               o_valid,
    output logic                               o_last
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_valid;
    logic                     n_valid;

    // next word and occupancy
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        case (i_ctl.op)
            C_SHIFT_IN: begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end
            C_SHIFT_OUT: begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
            C_APPEND: begin
                // first free cell: front-side neighbor is occupied
                if (!r_valid && i_left_valid) begin
                    n_data  = i_ctl.value;
                    n_valid = 1'b1;
                end
            end
            C_DROP_TAIL: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_data  = r_data;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid && !i_right_valid;

endmodule

[src/cdq_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_chain: row of deque cells, front word in cell 0
// Occupied cells always form a contiguous run from cell 0. Reports the
// front word, the back word (selected by the one-hot tail marks), and the
// empty and full flags.
// ----------------------------------------------------------------------------
module cdq_chain #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdq_pkg::t_cell_ctl   i_ctl,
    output cdq_pkg::t_chain_stat o_stat
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_last;
    logic signed [DATA_W-1:0] w_tail;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_ld;
            logic                     w_lv;
            logic signed [DATA_W-1:0] w_rd;
            logic                     w_rv;

            // front end is fed by the pushed word, back end by an empty slot
            if (g == 0) begin : g_head
                assign w_ld = i_ctl.value;
                assign w_lv = 1'b1;
            end else begin : g_mid_l
                assign w_ld = w_data[g-1];
                assign w_lv = w_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_rd = '0;
                assign w_rv = 1'b0;
            end else begin : g_mid_r
                assign w_rd = w_data[g+1];
                assign w_rv = w_valid[g+1];
            end

            cdq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (i_ctl),
                .i_left_data   (w_ld),
                .i_left_valid  (w_lv),
                .i_right_data  (w_rd),
                .i_right_valid (w_rv),
                .o_data        (w_data[g]),
                .o_valid       (w_valid[g]),
                .o_last        (w_last[g])
            );
        end
    endgenerate

    // back word: AND-OR select on the one-hot tail mark
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail = w_tail | (w_data[i] & {DATA_W{w_last[i]}});
        end
    end

    assign o_stat.front = w_data[0];
    assign o_stat.back  = w_tail;
    assign o_stat.empty = !w_valid[0];
    assign o_stat.full  = w_valid[DEPTH-1];

endmodule

[src/circular_double_ended_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_top: double-ended queue of signed words
//
// Input channel (i_valid / o_stall): one transaction per operation, kind
// 0 push front, 1 push back, 2 pop front, 3 pop back, with the word to push.
// Output channel (o_valid / i_stall): exactly one result per operation, in
// order: popped word (zero unless a pop succeeded), status (done, overflow,
// empty), front and back words afterwards (all ones when empty), and the
// empty and full flags afterwards.
// One operation per cycle is taken while the output side drains; the row
// of cells updates in the accept cycle, and the end words are sampled from
// it as the operation moves from stage 1 into the result register.
// The back word comes through a one-hot select across all DEPTH cells.
// Reset (synchronous, active low) empties the deque and drops any result
// in flight. A stalled receiver holds the result register; one further
// operation is held in the middle stage, after which o_stall rises.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_top #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_kind,
    input  logic signed [cdq_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [cdq_pkg::DATA_W-1:0]  o_popped_value,
    output logic [1:0]                         o_status,
    output logic signed [cdq_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [cdq_pkg::DATA_W-1:0]  o_back_value,
    output logic                               o_is_empty,
    output logic                               o_is_full
);
    import cdq_pkg::*;

    t_cell_ctl                w_ctl;
    t_chain_stat              w_stat;
    logic                     w_accept;
    logic                     w_s2_load;
    logic signed [DATA_W-1:0] w_popped;
    t_status                  w_status;

    // stage 1: outcome of the accepted operation
    logic                     r_s1_valid;
    logic                     n_s1_valid;
    logic signed [DATA_W-1:0] r_s1_popped;
    t_status                  r_s1_status;

    // stage 2: result register
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_out_popped;
    t_status                  r_out_status;
    logic signed [DATA_W-1:0] r_out_front;
    logic signed [DATA_W-1:0] r_out_back;
    logic                     r_out_empty;
    logic                     r_out_full;

    cdq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    // handshake
    assign w_s2_load = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !w_s2_load;
    assign w_accept  = i_valid && !o_stall;

    // operation decode against the current occupancy
    always_comb begin
        w_ctl.op    = C_HOLD;
        w_ctl.value = i_push_value;
        w_popped    = '0;
        w_status    = ST_DONE;
        case (t_kind'(i_kind))
            K_PUSH_FRONT: begin
                if (w_stat.full) begin
                    w_status = ST_OVERFLOW;
                end else begin
                    w_ctl.op = C_SHIFT_IN;
                end
            end
            K_PUSH_BACK: begin
                if (w_stat.full) begin
                    w_status = ST_OVERFLOW;
                end else begin
                    w_ctl.op = C_APPEND;
                end
            end
            K_POP_FRONT: begin
                if (w_stat.empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl.op = C_SHIFT_OUT;
                    w_popped = w_stat.front;
                end
            end
            K_POP_BACK: begin
                if (w_stat.empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl.op = C_DROP_TAIL;
                    w_popped = w_stat.back;
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
        if (!w_accept) begin
            w_ctl.op = C_HOLD;
        end
    end

    // stage valid bits
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s2_load) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_s2_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload; chain state sampled here reflects the operation in stage 1
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_popped <= w_popped;
            r_s1_status <= w_status;
        end
        if (w_s2_load) begin
            r_out_popped <= r_s1_popped;
            r_out_status <= r_s1_status;
            r_out_front  <= w_stat.empty ? EMPTY_WORD : w_stat.front;
            r_out_back   <= w_stat.empty ? EMPTY_WORD : w_stat.back;
            r_out_empty  <= w_stat.empty;
            r_out_full   <= w_stat.full;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_status       = r_out_status;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_is_empty     = r_out_empty;
    assign o_is_full      = r_out_full;

    // a refused push always reports a full deque
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVERFLOW) |-> o_is_full)
        else $error("overflow reported while not full");

    // a refused pop always reports an empty deque
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_is_empty && o_popped_value == '0))
        else $error("empty status with data or occupancy");

    // empty deque shows all-ones end words
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |->
            (o_front_value == EMPTY_WORD && o_back_value == EMPTY_WORD && !o_is_full))
        else $error("empty deque with bad end words");

    // chain never reports full and empty together
    a_chain_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.empty && w_stat.full))
        else $error("chain both empty and full");

    // a push taken on an empty deque leaves exactly that word at both ends
    a_first_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_stat.empty && !i_kind[1]) |=>
            (!w_stat.empty && w_stat.front == $past(i_push_value)
             && w_stat.back == $past(i_push_value)))
        else $error("first push not at both ends");

endmodule

[sim/circular_double_ended_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_top_tb: self-checking bench for the deque
// A short directed table covers empty pops, extreme words, filling to full,
// overflow and draining. It is followed by random grow/shrink phases with
// random gaps on both sides and one long receiver hold-off. Every result is
// compared field by field with its table expectation or an in-bench predictor.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_top_tb;
    import cdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int N_RANDOM    = 1600;
    localparam int N_QUIET     = 250;   // tail of the run without idling
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int PHASE_LEN   = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        t_status                  status;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic                     empty;
        logic                     full;
    } t_deque_result;

    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] value;
        logic                     has_exp;
        t_deque_result            exp;
    } t_stim_row;

    // DUT ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_kind;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_back_value;
    logic                     o_is_empty;
    logic                     o_is_full;

    // typed expectation travels with the transaction
    logic          item_has_exp;
    t_deque_result item_exp;

    // predictor state
    logic signed [DATA_W-1:0] dq_slot [DEPTH];
    int                       dq_head;
    int                       dq_tail;
    logic                     dq_live;

    t_deque_result pending_results [$];
    t_stim_row     dir_rows [$];

    int  n_err        = 0;
    int  n_ops        = 0;
    int  n_results    = 0;
    int  n_overflow   = 0;
    int  n_empty_pop  = 0;
    int  n_full_seen  = 0;
    int  n_in_stalled = 0;
    bit  random_started = 0;
    bit  quiet          = 0;

    circular_double_ended_queue_top #(.DEPTH(DEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Deque predictor
    // ------------------------------------------------------------------
    function automatic logic deque_is_full();
        return dq_live && (((dq_tail + 1) % DEPTH) == dq_head);
    endfunction

    function automatic t_deque_result apply_deque_op(t_kind kind,
                                                     logic signed [DATA_W-1:0] value);
        t_deque_result r;
        r = '0;
        r.status = ST_DONE;
        if (kind == K_PUSH_FRONT || kind == K_PUSH_BACK) begin
            if (!dq_live) begin
                // first word always lands in slot 0
                dq_head = 0;
                dq_tail = 0;
                dq_slot[0] = value;
                dq_live = 1'b1;
            end else if (deque_is_full()) begin
                r.status = ST_OVERFLOW;
            end else if (kind == K_PUSH_FRONT) begin
                dq_head = (dq_head + DEPTH - 1) % DEPTH;
                dq_slot[dq_head] = value;
            end else begin
                dq_tail = (dq_tail + 1) % DEPTH;
                dq_slot[dq_tail] = value;
            end
        end else begin
            if (!dq_live) begin
                r.status = ST_EMPTY;
            end else if (kind == K_POP_FRONT) begin
                r.popped = dq_slot[dq_head];
                if (dq_head == dq_tail) dq_live = 1'b0;
                else dq_head = (dq_head + 1) % DEPTH;
            end else begin
                r.popped = dq_slot[dq_tail];
                if (dq_head == dq_tail) dq_live = 1'b0;
                else dq_tail = (dq_tail + DEPTH - 1) % DEPTH;
            end
        end
        r.front = dq_live ? dq_slot[dq_head] : EMPTY_WORD;
        r.back  = dq_live ? dq_slot[dq_tail] : EMPTY_WORD;
        r.empty = !dq_live;
        r.full  = deque_is_full();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on input transaction, compare on output one
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [DATA_W-1:0] exp_v,
                               logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            n_err++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_deque_result pred;
        t_deque_result want;
        if (i_rst_n) begin
            if (i_valid && o_stall) n_in_stalled++;
            if (i_valid && !o_stall) begin
                pred = apply_deque_op(t_kind'(i_kind), i_push_value);
                pending_results.push_back(item_has_exp ? item_exp : pred);
                n_ops++;
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    n_err++;
                    $display("%0t ns: result with nothing expected, status %0d",
                             $time, o_status);
                end else begin
                    want = pending_results.pop_front();
                    n_results++;
                    if (want.status == ST_OVERFLOW) n_overflow++;
                    if (want.status == ST_EMPTY) n_empty_pop++;
                    if (want.full) n_full_seen++;
                    check_field("popped_value", want.popped, o_popped_value);
                    check_field("status", want.status, o_status);
                    check_field("front_value", want.front, o_front_value);
                    check_field("back_value", want.back, o_back_value);
                    check_field("is_empty", want.empty, o_is_empty);
                    check_field("is_full", want.full, o_is_full);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: long hold-off once random traffic starts, then bursts
    // ------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        wait (random_started);
        @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        i_stall <= 1'b0;
        while (!quiet) begin
            @(posedge i_clk);
            case ($urandom_range(0, 9))
                0, 1: begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
                2: repeat ($urandom_range(20, 60)) @(posedge i_clk);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_op(t_stim_row row);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= row.kind;
        i_push_value <= row.value;
        item_has_exp <= row.has_exp;
        item_exp     <= row.exp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_stim_row mk_row(t_kind kind, logic signed [DATA_W-1:0] value);
        t_stim_row r;
        r = '0;
        r.kind  = kind;
        r.value = value;
        return r;
    endfunction

    function automatic t_stim_row mk_checked(t_kind kind,
                                             logic signed [DATA_W-1:0] value,
                                             logic signed [DATA_W-1:0] popped,
                                             t_status status,
                                             logic signed [DATA_W-1:0] front,
                                             logic signed [DATA_W-1:0] back,
                                             logic empty);
        t_stim_row r;
        r = mk_row(kind, value);
        r.has_exp    = 1'b1;
        r.exp.popped = popped;
        r.exp.status = status;
        r.exp.front  = front;
        r.exp.back   = back;
        r.exp.empty  = empty;
        r.exp.full   = 1'b0;
        return r;
    endfunction

    initial begin
        t_stim_row                row;
        int                       push_bias;
        int                       pick;
        logic signed [DATA_W-1:0] val;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_kind       <= K_PUSH_FRONT;
        i_push_value <= '0;
        item_has_exp <= 1'b0;
        item_exp     <= '0;
        for (int k = 0; k < DEPTH; k++) dq_slot[k] = '0;
        dq_head = 0;
        dq_tail = 0;
        dq_live = 1'b0;

        // directed table: empty pops, extremes, fill, overflow, drain
        dir_rows.push_back(mk_checked(K_POP_FRONT, 32'sh0, 0, ST_EMPTY,
                                      EMPTY_WORD, EMPTY_WORD, 1'b1));
        dir_rows.push_back(mk_checked(K_POP_BACK, 32'sh1234, 0, ST_EMPTY,
                                      EMPTY_WORD, EMPTY_WORD, 1'b1));
        dir_rows.push_back(mk_checked(K_PUSH_BACK, 32'sh7FFF_FFFF, 0, ST_DONE,
                                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
        dir_rows.push_back(mk_checked(K_POP_FRONT, 32'sh0, 32'sh7FFF_FFFF, ST_DONE,
                                      EMPTY_WORD, EMPTY_WORD, 1'b1));
        dir_rows.push_back(mk_checked(K_PUSH_FRONT, 32'sh8000_0000, 0, ST_DONE,
                                      32'sh8000_0000, 32'sh8000_0000, 1'b0));
        dir_rows.push_back(mk_row(K_PUSH_BACK,  32'shFFFF_FFFF));
        dir_rows.push_back(mk_row(K_PUSH_FRONT, 32'sh0));
        dir_rows.push_back(mk_row(K_PUSH_BACK,  32'sh5555_5555));
        dir_rows.push_back(mk_row(K_PUSH_FRONT, 32'shAAAA_AAAA));
        dir_rows.push_back(mk_row(K_PUSH_BACK,  32'sh1));
        dir_rows.push_back(mk_row(K_PUSH_FRONT, 32'sh7FFF_FFFF));
        dir_rows.push_back(mk_row(K_PUSH_BACK,  32'sh8000_0000));   // now full
        dir_rows.push_back(mk_row(K_PUSH_FRONT, 32'sh42));          // overflow
        dir_rows.push_back(mk_row(K_PUSH_BACK,  32'sh43));          // overflow
        repeat (4) dir_rows.push_back(mk_row(K_POP_BACK, 32'sh0));
        repeat (4) dir_rows.push_back(mk_row(K_POP_FRONT, 32'sh0));
        dir_rows.push_back(mk_checked(K_POP_BACK, 32'sh0, 0, ST_EMPTY,
                                      EMPTY_WORD, EMPTY_WORD, 1'b1));
        // push into empty after the ends have wandered off slot 0
        dir_rows.push_back(mk_checked(K_PUSH_FRONT, 32'sh0BAD_F00D, 0, ST_DONE,
                                      32'sh0BAD_F00D, 32'sh0BAD_F00D, 1'b0));
        dir_rows.push_back(mk_checked(K_POP_BACK, 32'sh0, 32'sh0BAD_F00D, ST_DONE,
                                      EMPTY_WORD, EMPTY_WORD, 1'b1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) send_op(dir_rows[r]);

        // random part: grow, shrink or even-mix phases, each picked at random
        random_started = 1;
        push_bias = 75;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - N_QUIET) quiet = 1;
            if (n % PHASE_LEN == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    push_bias = 80;
                    2, 3:    push_bias = 20;
                    default: push_bias = 50;
                endcase
            end
            pick = $urandom_range(0, 9);
            case (pick)
                0:       val = 32'sh7FFF_FFFF;
                1:       val = 32'sh8000_0000;
                2:       val = -32'sd1;
                3:       val = 32'sh0;
                default: val = $urandom;
            endcase
            if ($urandom_range(0, 99) < push_bias)
                row = mk_row(t_kind'($urandom_range(0, 1)), val);
            else
                row = mk_row(t_kind'($urandom_range(2, 3)), val);
            send_op(row);
        end
        i_valid <= 1'b0;

        // drain and let any stray result show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d operations, checked %0d results (DEPTH %0d).",
                 n_ops, n_results, DEPTH);
        $display("Overflows %0d, empty pops %0d, full results %0d, stalled input cycles %0d.",
                 n_overflow, n_empty_pop, n_full_seen, n_in_stalled);
        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Timeout: %0d results still outstanding.", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
